>>> rtl/scc_pkg.sv
// Shared constants, codes and types for the SCC condensed max-path-sum block.
`default_nettype none

package scc_pkg;

    localparam int MAX_NODES_DEF   = 256;
    localparam int MAX_EDGES_DEF   = 1024;
    localparam int WEIGHT_BITS_DEF = 32;

    localparam int KIND_W   = 2;
    localparam int NODE_W   = 8;
    localparam int WEIGHT_W = 32;
    localparam int CFG_W    = 9;
    localparam int BEST_W   = 40;

    localparam logic [CFG_W-1:0] NODE_COUNT_RST = 9'd256;

    localparam logic signed [BEST_W-1:0] BEST_MAX = {1'b0, {(BEST_W-1){1'b1}}};
    localparam logic signed [BEST_W-1:0] BEST_MIN = {1'b1, {(BEST_W-1){1'b0}}};

    typedef enum logic [KIND_W-1:0] {
        KIND_WEIGHT  = 2'd0,
        KIND_EDGE    = 2'd1,
        KIND_COMPUTE = 2'd2
    } t_kind;

    typedef enum logic [4:0] {
        S_WCLR, S_IDLE, S_CLR, S_OUTER, S_FINW, S_SCHK, S_SCAN, S_EDGE, S_VCHK,
        S_POPW, S_SUM, S_SUMC, S_SUMW, S_DEG, S_DEGE, S_DEGC, S_DEGW, S_INIT,
        S_INITW, S_DEQ, S_DEQW, S_DEQB, S_REL, S_RELE, S_RELC, S_RELW, S_MAX,
        S_MAXW, S_OUT
    } t_state;

endpackage

`default_nettype wire

>>> rtl/scc_alu.sv
// Shared add and compare unit used by every sum and relaxation step.
`default_nettype none

module scc_alu #(
    parameter int AW = 41
) (
    input  wire logic signed [AW-1:0] i_a,
    input  wire logic signed [AW-1:0] i_b,
    input  wire logic signed [AW-1:0] i_c,
    output logic signed [AW-1:0]      o_sum,
    output logic                      o_gt
);

    assign o_sum = i_a + i_b;
    // true when the sum beats the compare operand
    assign o_gt  = (o_sum > i_c);

endmodule

`default_nettype wire

>>> rtl/scc_condensed_max_path_sum.sv
// Top level: graph loader, Kosaraju SCC sequencer and condensed-DAG longest path.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+-----------------------------------
//  input    | in        | i_in_valid / o_in_ready      | i_kind, i_node_a, i_node_b, i_weight
//  result   | out       | o_out_valid / i_out_ready    | o_best_sum, o_edges_dropped
//  config   | in        | i_cfg_we (no wait)           | i_cfg_wdata = node_count
//
// Weight and edge items transfer back to back.
// A compute item scans the stored edge list serially, one edge at a time, inside
// each depth-first frame and again in the degree and relaxation passes, since the
// edge memory has a single read address.
// After reset, and after every compute, a sweep over all MAX_NODES entries clears the
// node weights; no input item transfers during it.
// A waiting result does not stop weight and edge items; only the next compute
// item stalls until the result has been taken.
`default_nettype none

module scc_condensed_max_path_sum
    import scc_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int MAX_EDGES   = MAX_EDGES_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_W-1:0]           i_cfg_wdata,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [KIND_W-1:0]          i_kind,
    input  wire logic [NODE_W-1:0]          i_node_a,
    input  wire logic [NODE_W-1:0]          i_node_b,
    input  wire logic signed [WEIGHT_W-1:0] i_weight,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic signed [BEST_W-1:0]        o_best_sum,
    output logic                            o_edges_dropped
);

    localparam int NW  = $clog2(MAX_NODES);            // node index
    localparam int CW  = NW + 1;                       // node counter
    localparam int XW  = (CW > CFG_W) ? CW : CFG_W;    // config compare width
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);        // edge counter
    localparam int AW  = WEIGHT_BITS + NW + 1;         // sum width
    localparam int EXW = (AW > BEST_W) ? AW : BEST_W;

    // ---------------- state and registers ----------------
    t_state r_state, n_state;
    logic [CFG_W-1:0] r_cfg;
    logic [CW-1:0]  r_i, n_i, r_fin, n_fin, r_comps, n_comps, r_sp, n_sp;
    logic [CW-1:0]  r_head, n_head, r_tail, n_tail;
    logic [ECW-1:0] r_e, n_e, r_etot, n_etot;
    logic           r_ovf, n_ovf, r_pass, n_pass, r_out_valid, n_out_valid;
    logic [NW-1:0]  r_v, n_v, r_b, n_b, r_t, n_t, r_u, n_u;
    logic signed [WEIGHT_BITS-1:0] r_w, n_w;
    logic signed [AW-1:0] r_bpu, n_bpu, r_best, n_best;
    logic signed [BEST_W-1:0] r_best_out, n_best_out;
    logic r_drop, n_drop;

    // ---------------- memories ----------------
    logic signed [WEIGHT_BITS-1:0] r_wt_mem [MAX_NODES];
    logic [NW-1:0]  r_ef_mem   [MAX_EDGES];
    logic [NW-1:0]  r_et_mem   [MAX_EDGES];
    logic           r_vis_mem  [MAX_NODES];
    logic [NW-1:0]  r_stkv_mem [MAX_NODES];
    logic [ECW-1:0] r_stke_mem [MAX_NODES];
    logic [NW-1:0]  r_fin_mem  [MAX_NODES];
    logic [NW-1:0]  r_comp_mem [MAX_NODES];
    logic signed [AW-1:0] r_cw_mem [MAX_NODES];
    logic [ECW-1:0] r_deg_mem  [MAX_NODES];
    logic signed [AW-1:0] r_bp_mem [MAX_NODES];
    logic [NW-1:0]  r_ff_mem   [MAX_NODES];

    logic signed [WEIGHT_BITS-1:0] r_wt_rd;
    logic [NW-1:0]  r_ef_rd, r_et_rd, r_stkv_rd, r_fin_rd, r_comp_a_rd, r_comp_b_rd, r_ff_rd;
    logic           r_vis_rd;
    logic [ECW-1:0] r_stke_rd, r_deg_rd;
    logic signed [AW-1:0] r_cw_rd, r_bp_rd;

    // memory controls
    logic wt_we, e_we, vis_we, vis_wd, stk_we, fin_we, comp_we, cw_we, deg_we, bp_we, ff_we;
    logic [NW-1:0] wt_wa, vis_wa, vis_ra, comp_wa, comp_raa, comp_rab;
    logic [NW-1:0] cw_wa, cw_ra, deg_wa, deg_ra, bp_wa, bp_ra, ff_wd;
    logic signed [WEIGHT_BITS-1:0] wt_wd;
    logic signed [AW-1:0] cw_wd, bp_wd;
    logic [ECW-1:0] deg_wd;

    // ---------------- derived values ----------------
    logic [XW-1:0] w_n_x;
    logic [CW-1:0] w_n, w_n_m1, w_i_m1, w_sp_m1, w_sp_m2;
    logic          w_acc, w_out_take, w_in_rng, w_edge_hit;
    logic [NW-1:0] w_ea, w_eb;
    logic signed [AW-1:0] alu_a, alu_b, alu_c, alu_sum;
    logic          alu_gt;
    logic signed [EXW-1:0] w_best_x;
    logic signed [BEST_W-1:0] w_best_sat;

    // Clamp node_count: zero acts as one, above capacity acts as capacity.
    always_comb begin
        if (r_cfg == '0) begin
            w_n_x = XW'(1);
        end else if (XW'(r_cfg) > XW'(MAX_NODES)) begin
            w_n_x = XW'(MAX_NODES);
        end else begin
            w_n_x = XW'(r_cfg);
        end
    end
    assign w_n     = w_n_x[CW-1:0];
    assign w_n_m1  = w_n - CW'(1);
    assign w_i_m1  = r_i - CW'(1);
    assign w_sp_m1 = r_sp - CW'(1);
    assign w_sp_m2 = r_sp - CW'(2);

    // Hold a compute item while the previous result still waits.
    assign o_in_ready = (r_state == S_IDLE) && !(r_out_valid && (i_kind == KIND_COMPUTE));
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_out_take = r_out_valid && i_out_ready;

    // Forward pass walks from->to; the reverse pass walks to->from.
    assign w_ea       = r_pass ? r_et_rd : r_ef_rd;
    assign w_eb       = r_pass ? r_ef_rd : r_et_rd;
    // Skip edges that touch nodes beyond the active count.
    assign w_in_rng   = (CW'(r_ef_rd) < w_n) && (CW'(r_et_rd) < w_n);
    assign w_edge_hit = (w_ea == r_v) && w_in_rng;

    // ---------------- shared add/compare unit ----------------
    always_comb begin
        case (r_state)
            S_SUMW: begin
                alu_a = AW'(r_w);
                alu_b = r_cw_rd;
                alu_c = '0;
            end
            S_RELW: begin
                alu_a = r_bpu;
                alu_b = r_cw_rd;
                alu_c = r_bp_rd;
            end
            default: begin
                alu_a = r_bp_rd;
                alu_b = '0;
                alu_c = r_best;
            end
        endcase
    end

    scc_alu #(.AW(AW)) u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_c   (alu_c),
        .o_sum (alu_sum),
        .o_gt  (alu_gt)
    );

    // Saturate the best sum to the result width.
    assign w_best_x = EXW'(r_best);
    always_comb begin
        if (w_best_x > EXW'(BEST_MAX)) begin
            w_best_sat = BEST_MAX;
        end else if (w_best_x < EXW'(BEST_MIN)) begin
            w_best_sat = BEST_MIN;
        end else begin
            w_best_sat = w_best_x[BEST_W-1:0];
        end
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_WCLR:  if (r_i == CW'(MAX_NODES - 1)) n_state = S_IDLE;
            S_IDLE:  if (w_acc && (i_kind == KIND_COMPUTE)) n_state = S_CLR;
            S_CLR:   if (r_i == w_n_m1) n_state = S_OUTER;
            S_OUTER: begin
                if (!r_pass) begin
                    n_state = (r_i == w_n) ? S_CLR : S_SCHK;
                end else begin
                    n_state = (r_i == '0) ? S_SUM : S_FINW;
                end
            end
            S_FINW:  n_state = S_SCHK;
            S_SCHK:  n_state = r_vis_rd ? S_OUTER : S_SCAN;
            S_SCAN: begin
                if (r_e == r_etot) begin
                    n_state = (r_sp == CW'(1)) ? S_OUTER : S_POPW;
                end else begin
                    n_state = S_EDGE;
                end
            end
            S_EDGE:  n_state = w_edge_hit ? S_VCHK : S_SCAN;
            S_VCHK:  n_state = S_SCAN;
            S_POPW:  n_state = S_SCAN;
            S_SUM:   n_state = (r_i == w_n) ? S_DEG : S_SUMC;
            S_SUMC:  n_state = S_SUMW;
            S_SUMW:  n_state = S_SUM;
            S_DEG:   n_state = (r_e == r_etot) ? S_INIT : S_DEGE;
            S_DEGE:  n_state = w_in_rng ? S_DEGC : S_DEG;
            S_DEGC:  n_state = (r_comp_a_rd != r_comp_b_rd) ? S_DEGW : S_DEG;
            S_DEGW:  n_state = S_DEG;
            S_INIT:  n_state = (r_i == r_comps) ? S_DEQ : S_INITW;
            S_INITW: n_state = S_INIT;
            S_DEQ:   n_state = (r_head == r_tail) ? S_MAX : S_DEQW;
            S_DEQW:  n_state = S_DEQB;
            S_DEQB:  n_state = S_REL;
            S_REL:   n_state = (r_e == r_etot) ? S_DEQ : S_RELE;
            S_RELE:  n_state = w_in_rng ? S_RELC : S_REL;
            S_RELC: begin
                if ((r_comp_a_rd == r_u) && (r_comp_b_rd != r_u)) begin
                    n_state = S_RELW;
                end else begin
                    n_state = S_REL;
                end
            end
            S_RELW:  n_state = S_REL;
            S_MAX:   n_state = (r_i == r_comps) ? S_OUT : S_MAXW;
            S_MAXW:  n_state = S_MAX;
            S_OUT:   n_state = S_WCLR;
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- datapath and memory controls ----------------
    always_comb begin
        n_i = r_i;  n_fin = r_fin;  n_comps = r_comps;  n_sp = r_sp;
        n_head = r_head;  n_tail = r_tail;  n_e = r_e;  n_etot = r_etot;
        n_ovf = r_ovf;  n_pass = r_pass;  n_out_valid = r_out_valid;
        n_v = r_v;  n_b = r_b;  n_t = r_t;  n_u = r_u;  n_w = r_w;
        n_bpu = r_bpu;  n_best = r_best;  n_best_out = r_best_out;  n_drop = r_drop;

        wt_we = 1'b0;  wt_wa = r_i[NW-1:0];  wt_wd = '0;
        e_we = 1'b0;
        vis_we = 1'b0;  vis_wa = r_v;  vis_wd = 1'b0;  vis_ra = r_i[NW-1:0];
        stk_we = 1'b0;  fin_we = 1'b0;
        comp_we = 1'b0;  comp_wa = r_v;  comp_raa = r_ef_rd;  comp_rab = r_et_rd;
        cw_we = 1'b0;  cw_wa = r_t;  cw_wd = '0;  cw_ra = r_i[NW-1:0];
        deg_we = 1'b0;  deg_wa = r_t;  deg_wd = '0;  deg_ra = r_i[NW-1:0];
        bp_we = 1'b0;  bp_wa = r_t;  bp_wd = '0;  bp_ra = r_i[NW-1:0];
        ff_we = 1'b0;  ff_wd = r_t;

        // drop the result once the consumer takes it
        if (w_out_take) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_WCLR: begin
                wt_we = 1'b1;
                n_i   = (r_i == CW'(MAX_NODES - 1)) ? '0 : r_i + CW'(1);
            end
            S_IDLE: begin
                if (w_acc) begin
                    case (i_kind)
                        KIND_WEIGHT: begin
                            if (XW'(i_node_a) < w_n_x) begin
                                wt_we = 1'b1;
                                wt_wa = NW'(i_node_a);
                                wt_wd = WEIGHT_BITS'(i_weight);
                            end
                        end
                        KIND_EDGE: begin
                            if ((XW'(i_node_a) < w_n_x) && (XW'(i_node_b) < w_n_x)) begin
                                if (r_etot < ECW'(MAX_EDGES)) begin
                                    e_we   = 1'b1;
                                    n_etot = r_etot + ECW'(1);
                                end else begin
                                    n_ovf = 1'b1;
                                end
                            end
                        end
                        KIND_COMPUTE: begin
                            n_i     = '0;
                            n_pass  = 1'b0;
                            n_fin   = '0;
                            n_comps = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_CLR: begin
                // clear marks; component sums and degrees ride along
                vis_we = 1'b1;  vis_wa = r_i[NW-1:0];
                cw_we  = 1'b1;  cw_wa  = r_i[NW-1:0];
                deg_we = 1'b1;  deg_wa = r_i[NW-1:0];
                if (r_i == w_n_m1) begin
                    n_i = r_pass ? r_fin : '0;
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            S_OUTER: begin
                if (!r_pass) begin
                    if (r_i == w_n) begin
                        n_pass = 1'b1;
                        n_i    = '0;
                    end else begin
                        n_v = r_i[NW-1:0];
                    end
                end
            end
            S_FINW: begin
                n_v    = r_fin_rd;
                vis_ra = r_fin_rd;
            end
            S_SCHK: begin
                if (r_vis_rd) begin
                    n_i = r_pass ? w_i_m1 : r_i + CW'(1);
                end else begin
                    vis_we  = 1'b1;
                    vis_wd  = 1'b1;
                    comp_we = r_pass;
                    n_e     = '0;
                    n_sp    = CW'(1);
                end
            end
            S_SCAN: begin
                if (r_e == r_etot) begin
                    // frame exhausted: record finish on the forward pass, then pop
                    if (!r_pass) begin
                        fin_we = 1'b1;
                        n_fin  = r_fin + CW'(1);
                    end
                    if (r_sp == CW'(1)) begin
                        if (r_pass) begin
                            n_comps = r_comps + CW'(1);
                        end
                        n_i = r_pass ? w_i_m1 : r_i + CW'(1);
                    end
                end else begin
                    n_e = r_e + ECW'(1);
                end
            end
            S_EDGE: begin
                n_b    = w_eb;
                vis_ra = w_eb;
            end
            S_VCHK: begin
                if (!r_vis_rd) begin
                    vis_we  = 1'b1;
                    vis_wa  = r_b;
                    vis_wd  = 1'b1;
                    comp_we = r_pass;
                    comp_wa = r_b;
                    stk_we  = 1'b1;
                    n_v     = r_b;
                    n_e     = '0;
                    n_sp    = r_sp + CW'(1);
                end
            end
            S_POPW: begin
                n_v  = r_stkv_rd;
                n_e  = r_stke_rd;
                n_sp = w_sp_m1;
            end
            S_SUM: begin
                comp_raa = r_i[NW-1:0];
                if (r_i == w_n) begin
                    n_e = '0;
                end
            end
            S_SUMC: begin
                n_t   = r_comp_a_rd;
                n_w   = r_wt_rd;
                cw_ra = r_comp_a_rd;
            end
            S_SUMW: begin
                cw_we = 1'b1;
                cw_wd = alu_sum;
                n_i   = r_i + CW'(1);
            end
            S_DEG: begin
                if (r_e == r_etot) begin
                    n_i    = '0;
                    n_tail = '0;
                end else begin
                    n_e = r_e + ECW'(1);
                end
            end
            S_DEGE: ;
            S_DEGC: begin
                n_t    = r_comp_b_rd;
                deg_ra = r_comp_b_rd;
            end
            S_DEGW: begin
                deg_we = 1'b1;
                deg_wd = r_deg_rd + ECW'(1);
            end
            S_INIT: begin
                if (r_i == r_comps) begin
                    n_head = '0;
                end
            end
            S_INITW: begin
                bp_we = 1'b1;
                bp_wa = r_i[NW-1:0];
                bp_wd = r_cw_rd;
                if (r_deg_rd == '0) begin
                    ff_we  = 1'b1;
                    ff_wd  = r_i[NW-1:0];
                    n_tail = r_tail + CW'(1);
                end
                n_i = r_i + CW'(1);
            end
            S_DEQ: begin
                if (r_head == r_tail) begin
                    n_i = '0;
                end else begin
                    n_head = r_head + CW'(1);
                end
            end
            S_DEQW: begin
                n_u   = r_ff_rd;
                bp_ra = r_ff_rd;
            end
            S_DEQB: begin
                n_bpu = r_bp_rd;
                n_e   = '0;
            end
            S_REL: begin
                if (r_e != r_etot) begin
                    n_e = r_e + ECW'(1);
                end
            end
            S_RELE: ;
            S_RELC: begin
                n_t    = r_comp_b_rd;
                cw_ra  = r_comp_b_rd;
                deg_ra = r_comp_b_rd;
                bp_ra  = r_comp_b_rd;
            end
            S_RELW: begin
                if (alu_gt) begin
                    bp_we = 1'b1;
                    bp_wd = alu_sum;
                end
                deg_we = 1'b1;
                deg_wd = r_deg_rd - ECW'(1);
                if (r_deg_rd == ECW'(1)) begin
                    ff_we  = 1'b1;
                    n_tail = r_tail + CW'(1);
                end
            end
            S_MAX: ;
            S_MAXW: begin
                if ((r_i == '0) || alu_gt) begin
                    n_best = r_bp_rd;
                end
                n_i = r_i + CW'(1);
            end
            S_OUT: begin
                n_out_valid = 1'b1;
                n_best_out  = w_best_sat;
                n_drop      = r_ovf;
                n_ovf       = 1'b0;
                n_etot      = '0;
                n_i         = '0;
            end
            default: ;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_WCLR;
            r_cfg       <= NODE_COUNT_RST;
            r_i         <= '0;
            r_fin       <= '0;
            r_comps     <= '0;
            r_sp        <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_e         <= '0;
            r_etot      <= '0;
            r_ovf       <= 1'b0;
            r_pass      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            r_i         <= n_i;
            r_fin       <= n_fin;
            r_comps     <= n_comps;
            r_sp        <= n_sp;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_e         <= n_e;
            r_etot      <= n_etot;
            r_ovf       <= n_ovf;
            r_pass      <= n_pass;
            r_out_valid <= n_out_valid;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        r_v        <= n_v;
        r_b        <= n_b;
        r_t        <= n_t;
        r_u        <= n_u;
        r_w        <= n_w;
        r_bpu      <= n_bpu;
        r_best     <= n_best;
        r_best_out <= n_best_out;
        r_drop     <= n_drop;
    end

    // ---------------- memory ports ----------------
    always_ff @(posedge i_clk) begin
        if (wt_we) r_wt_mem[wt_wa] <= wt_wd;
        r_wt_rd <= r_wt_mem[r_i[NW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (e_we) begin
            r_ef_mem[r_etot[EAW-1:0]] <= NW'(i_node_a);
            r_et_mem[r_etot[EAW-1:0]] <= NW'(i_node_b);
        end
        r_ef_rd <= r_ef_mem[r_e[EAW-1:0]];
        r_et_rd <= r_et_mem[r_e[EAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (vis_we) r_vis_mem[vis_wa] <= vis_wd;
        r_vis_rd <= r_vis_mem[vis_ra];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stkv_mem[w_sp_m1[NW-1:0]] <= r_v;
            r_stke_mem[w_sp_m1[NW-1:0]] <= r_e;
        end
        r_stkv_rd <= r_stkv_mem[w_sp_m2[NW-1:0]];
        r_stke_rd <= r_stke_mem[w_sp_m2[NW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (fin_we) r_fin_mem[r_fin[NW-1:0]] <= r_v;
        r_fin_rd <= r_fin_mem[w_i_m1[NW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (comp_we) r_comp_mem[comp_wa] <= r_comps[NW-1:0];
        r_comp_a_rd <= r_comp_mem[comp_raa];
        r_comp_b_rd <= r_comp_mem[comp_rab];
    end

    always_ff @(posedge i_clk) begin
        if (cw_we) r_cw_mem[cw_wa] <= cw_wd;
        r_cw_rd <= r_cw_mem[cw_ra];
    end

    always_ff @(posedge i_clk) begin
        if (deg_we) r_deg_mem[deg_wa] <= deg_wd;
        r_deg_rd <= r_deg_mem[deg_ra];
    end

    always_ff @(posedge i_clk) begin
        if (bp_we) r_bp_mem[bp_wa] <= bp_wd;
        r_bp_rd <= r_bp_mem[bp_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ff_we) r_ff_mem[r_tail[NW-1:0]] <= ff_wd;
        r_ff_rd <= r_ff_mem[r_head[NW-1:0]];
    end

    assign o_out_valid     = r_out_valid;
    assign o_best_sum      = r_best_out;
    assign o_edges_dropped = r_drop;

endmodule

`default_nettype wire

>>> rtl/scc_chk.sv
// Port-level checker for the SCC block, bound to the top level.
`default_nettype none

module scc_chk
    import scc_pkg::*;
(
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_cfg_we,
    input wire logic [CFG_W-1:0]           i_cfg_wdata,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_ready,
    input wire logic [KIND_W-1:0]          i_kind,
    input wire logic [NODE_W-1:0]          i_node_a,
    input wire logic [NODE_W-1:0]          i_node_b,
    input wire logic signed [WEIGHT_W-1:0] i_weight,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_ready,
    input wire logic signed [BEST_W-1:0]   o_best_sum,
    input wire logic                       o_edges_dropped
);

    // a compute transfer starts a multi-cycle walk
    a_busy_after_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_kind == KIND_COMPUTE)) |=> !o_in_ready)
        else $error("input ready right after a compute transfer");

    // a result appears only at the end of a busy period
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result raised while the block was idle");

    // a pending result holds back the next compute
    a_compute_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_in_valid && (i_kind == KIND_COMPUTE)) |-> !o_in_ready)
        else $error("compute accepted while a result waits");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_best_sum) && $stable(o_edges_dropped)))
        else $error("stalled result changed");

endmodule

bind scc_condensed_max_path_sum scc_chk u_scc_chk (.*);

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for the SCC condensed max-path-sum block.
module tb_top;
    import scc_pkg::*;

    // Clock, reset and DUT ports
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_W-1:0]           cfg_wdata = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [KIND_W-1:0]          in_kind = '0;
    logic [NODE_W-1:0]          in_node_a = '0;
    logic [NODE_W-1:0]          in_node_b = '0;
    logic signed [WEIGHT_W-1:0] in_weight = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [BEST_W-1:0]   out_best_sum;
    logic                       out_edges_dropped;

    localparam int NODES   = MAX_NODES_DEF;
    localparam int EDGES   = MAX_EDGES_DEF;
    localparam int KIND_NOP = 3;   // unused kind code, ignored by the block

    typedef struct {
        logic [KIND_W-1:0]          kind;
        logic [NODE_W-1:0]          node_a;
        logic [NODE_W-1:0]          node_b;
        logic signed [WEIGHT_W-1:0] weight;
    } graph_item_t;

    typedef struct {
        logic signed [BEST_W-1:0] best_sum;
        logic                     dropped;
    } path_result_t;

    graph_item_t  item_queue[$];
    path_result_t expected_sums[$];

    // Predictor state: loaded graph plus scratch for the two graph walks
    logic [CFG_W-1:0]           node_count_reg = NODE_COUNT_RST;
    logic signed [WEIGHT_W-1:0] g_weight [NODES];
    logic [NODE_W-1:0]          g_from [EDGES];
    logic [NODE_W-1:0]          g_to [EDGES];
    int                         g_edge_cnt = 0;
    bit                         g_overflow = 0;
    bit                         seen [NODES];
    int                         walk_node [NODES];
    int                         walk_next [NODES];
    int                         done_order [NODES];
    int                         done_cnt;
    int                         scc_id [NODES];

    int  err_count = 0;
    int  items_sent = 0;
    int  sums_checked = 0;
    int  cfg_writes = 0;
    bit  calm = 0;        // no idling on either side during this phase
    bit  in_busy = 0;
    bit  in_fired = 0;
    bit  out_fired = 0;
    int  in_gap = 0;
    int  out_gap = 0;

    scc_condensed_max_path_sum u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_kind          (in_kind),
        .i_node_a        (in_node_a),
        .i_node_b        (in_node_b),
        .i_weight        (in_weight),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_best_sum      (out_best_sum),
        .o_edges_dropped (out_edges_dropped)
    );

    always #5 i_clk = ~i_clk;

    function automatic int active_nodes();
        int n;
        n = node_count_reg;
        if (n == 0) n = 1;
        if (n > NODES) n = NODES;
        return n;
    endfunction

    // Depth-first walk with an explicit stack; forward walk records finish
    // order, reverse walk labels every reached node with the component id.
    function automatic void graph_walk(int start, int n, bit rev, int cid);
        int  sp;
        int  v;
        int  e;
        int  a;
        int  b;
        bit  pushed;
        seen[start] = 1;
        if (rev) scc_id[start] = cid;
        walk_node[0] = start;
        walk_next[0] = 0;
        sp = 1;
        while (sp > 0) begin
            v = walk_node[sp-1];
            e = walk_next[sp-1];
            pushed = 0;
            while (e < g_edge_cnt && !pushed) begin
                a = rev ? g_to[e] : g_from[e];
                b = rev ? g_from[e] : g_to[e];
                e++;
                if (a == v && a < n && b < n && !seen[b]) begin
                    walk_next[sp-1] = e;
                    seen[b] = 1;
                    if (rev) scc_id[b] = cid;
                    walk_node[sp] = b;
                    walk_next[sp] = 0;
                    sp++;
                    pushed = 1;
                end
            end
            if (!pushed) begin
                sp--;
                if (!rev) begin
                    done_order[done_cnt] = v;
                    done_cnt++;
                end
            end
        end
    endfunction

    // Largest component-weighted path over the condensed DAG.
    function automatic longint max_path_sum();
        int     n;
        int     comps;
        int     head;
        int     tail;
        int     u;
        int     t;
        int     v;
        longint scc_sum [NODES];
        int     indeg [NODES];
        longint best_to [NODES];
        int     ready_list [NODES];
        longint best;
        n = active_nodes();
        comps = 0;
        head = 0;
        tail = 0;
        done_cnt = 0;
        foreach (seen[i]) seen[i] = 0;
        for (int i = 0; i < n; i++)
            if (!seen[i]) graph_walk(i, n, 1'b0, 0);
        foreach (seen[i]) seen[i] = 0;
        for (int i = done_cnt; i > 0; i--) begin
            v = done_order[i-1];
            if (!seen[v]) begin
                graph_walk(v, n, 1'b1, comps);
                comps++;
            end
        end
        foreach (scc_sum[i]) begin
            scc_sum[i] = 0;
            indeg[i] = 0;
        end
        for (int i = 0; i < n; i++) scc_sum[scc_id[i]] += longint'(g_weight[i]);
        for (int e = 0; e < g_edge_cnt; e++) begin
            if (g_from[e] >= n || g_to[e] >= n) continue;
            if (scc_id[g_from[e]] != scc_id[g_to[e]]) indeg[scc_id[g_to[e]]]++;
        end
        for (int i = 0; i < comps; i++) begin
            best_to[i] = scc_sum[i];
            if (indeg[i] == 0) begin
                ready_list[tail] = i;
                tail++;
            end
        end
        // Relax in topological order; queue order does not change the answer
        while (head < tail) begin
            u = ready_list[head];
            head++;
            for (int e = 0; e < g_edge_cnt; e++) begin
                if (g_from[e] >= n || g_to[e] >= n) continue;
                if (scc_id[g_from[e]] != u) continue;
                t = scc_id[g_to[e]];
                if (t == u) continue;
                if (best_to[t] < best_to[u] + scc_sum[t]) best_to[t] = best_to[u] + scc_sum[t];
                indeg[t]--;
                if (indeg[t] == 0) begin
                    ready_list[tail] = t;
                    tail++;
                end
            end
        end
        best = best_to[0];
        for (int i = 1; i < comps; i++)
            if (best_to[i] > best) best = best_to[i];
        if (best > longint'(BEST_MAX)) best = longint'(BEST_MAX);
        if (best < longint'(BEST_MIN)) best = longint'(BEST_MIN);
        return best;
    endfunction

    // Advance the predictor by one transferred item.
    function automatic void predict_item(graph_item_t it);
        int           n;
        path_result_t r;
        n = active_nodes();
        case (it.kind)
            KIND_WEIGHT: begin
                if (it.node_a < n) g_weight[it.node_a] = it.weight;
            end
            KIND_EDGE: begin
                if (it.node_a < n && it.node_b < n) begin
                    if (g_edge_cnt < EDGES) begin
                        g_from[g_edge_cnt] = it.node_a;
                        g_to[g_edge_cnt] = it.node_b;
                        g_edge_cnt++;
                    end else begin
                        g_overflow = 1;
                    end
                end
            end
            KIND_COMPUTE: begin
                r.best_sum = BEST_W'(max_path_sum());
                r.dropped = g_overflow;
                expected_sums.push_back(r);
                foreach (g_weight[i]) g_weight[i] = '0;
                g_edge_cnt = 0;
                g_overflow = 0;
            end
            default: ;
        endcase
    endfunction

    // Sample both channels at the rising edge; predict and check here.
    always @(posedge i_clk) begin
        path_result_t exp_r;
        graph_item_t  took;
        if (i_rst_n) begin
            if (in_valid && in_ready) begin
                took.kind = in_kind;
                took.node_a = in_node_a;
                took.node_b = in_node_b;
                took.weight = in_weight;
                predict_item(took);
                items_sent++;
                in_fired = 1;
            end
            if (out_valid && out_ready) begin
                out_fired = 1;
                if (expected_sums.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("ERROR: unexpected result sum=%0d dropped=%0b",
                                 out_best_sum, out_edges_dropped);
                end else begin
                    exp_r = expected_sums.pop_front();
                    sums_checked++;
                    if (out_best_sum !== exp_r.best_sum ||
                        out_edges_dropped !== exp_r.dropped) begin
                        err_count++;
                        if (err_count <= 10)
                            $display("ERROR: result %0d: sum exp %0d got %0d, dropped exp %0b got %0b",
                                     sums_checked, exp_r.best_sum, out_best_sum,
                                     exp_r.dropped, out_edges_dropped);
                    end
                end
            end
        end
    end

    // Input driver: present the next item at the falling edge, hold until transfer.
    always @(negedge i_clk) begin
        graph_item_t nxt;
        if (i_rst_n) begin
            if (in_fired) begin
                in_fired = 0;
                in_busy = 0;
                in_gap = calm ? 0 : $urandom_range(0, 3);
            end
            if (!in_busy) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (item_queue.size() > 0) begin
                    nxt = item_queue.pop_front();
                    in_kind <= nxt.kind;
                    in_node_a <= nxt.node_a;
                    in_node_b <= nxt.node_b;
                    in_weight <= nxt.weight;
                    in_busy = 1;
                end
            end
            in_valid <= in_busy;
        end
    end

    // Result side: stall a random number of cycles before each transfer.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_fired) begin
                out_fired = 0;
                out_gap = calm ? 0 : $urandom_range(0, 3);
            end else if (out_gap > 0) begin
                out_gap--;
            end
            out_ready <= (out_gap == 0);
        end
    end

    task automatic push_item(int kind, int a, int b, logic signed [WEIGHT_W-1:0] w);
        graph_item_t it;
        it.kind = kind;
        it.node_a = a;
        it.node_b = b;
        it.weight = w;
        item_queue.push_back(it);
    endtask

    // Wait until every item is out and every result is in, then let the
    // block finish its clearing sweep before touching the register.
    task automatic wait_idle();
        while (item_queue.size() > 0 || in_busy || expected_sums.size() > 0)
            @(negedge i_clk);
        repeat (NODES + 64) @(negedge i_clk);
    endtask

    task automatic write_node_count(int value);
        wait_idle();
        cfg_we = 1'b1;
        cfg_wdata = value;
        node_count_reg = value;
        cfg_writes++;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // One random graph: mostly well-formed loads inside the node range,
    // some noise with any endpoint and the unused kind, then a compute.
    task automatic random_graph(int n_lim, int loads);
        int pick;
        for (int k = 0; k < loads; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                push_item(KIND_WEIGHT, $urandom_range(0, n_lim-1), $urandom_range(0, 255),
                          $urandom());
            else if (pick < 85)
                push_item(KIND_EDGE, $urandom_range(0, n_lim-1), $urandom_range(0, n_lim-1),
                          $urandom());
            else if (pick < 95)
                push_item($urandom_range(0, 1), $urandom_range(0, 255),
                          $urandom_range(0, 255), $urandom());
            else
                push_item(KIND_NOP, $urandom_range(0, 255), $urandom_range(0, 255), $urandom());
        end
        push_item(KIND_COMPUTE, $urandom_range(0, 255), $urandom_range(0, 255), $urandom());
    endtask

    initial begin
        int n_pick;
        int lim;
        foreach (g_weight[i]) g_weight[i] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset node count, extreme weights, a two-node cycle, unused kind
        push_item(KIND_WEIGHT, 0, 0, 32'sh7fffffff);
        push_item(KIND_WEIGHT, 255, 255, 32'sh80000000);
        push_item(KIND_WEIGHT, 254, 0, 32'sh7fffffff);
        push_item(KIND_EDGE, 0, 255, 0);
        push_item(KIND_EDGE, 255, 0, 0);
        push_item(KIND_EDGE, 255, 254, 0);
        push_item(KIND_NOP, 255, 255, 32'sh7fffffff);
        push_item(KIND_COMPUTE, 0, 0, 0);
        push_item(KIND_COMPUTE, 0, 0, 0);          // empty graph after clearing
        // Node count zero acts as one; out-of-range weight and edge are ignored
        write_node_count(0);
        push_item(KIND_WEIGHT, 0, 0, -5);
        push_item(KIND_WEIGHT, 1, 0, 100);
        push_item(KIND_EDGE, 0, 0, 0);
        push_item(KIND_EDGE, 0, 1, 0);
        push_item(KIND_COMPUTE, 0, 0, 0);
        // Load a chain, then lower the node count before computing
        write_node_count(3);
        push_item(KIND_WEIGHT, 0, 0, 10);
        push_item(KIND_WEIGHT, 1, 0, 20);
        push_item(KIND_WEIGHT, 2, 0, 40);
        push_item(KIND_EDGE, 0, 1, 0);
        push_item(KIND_EDGE, 1, 2, 0);
        wait_idle();
        write_node_count(2);
        push_item(KIND_COMPUTE, 0, 0, 0);
        // Node count above range acts as the maximum
        write_node_count(511);
        push_item(KIND_WEIGHT, 255, 0, 7);
        push_item(KIND_EDGE, 200, 255, 0);
        push_item(KIND_COMPUTE, 0, 0, 0);

        // Edge list full: fill it past capacity on a tiny graph, then confirm
        // the flag clears on the next compute
        write_node_count(4);
        for (int k = 0; k < EDGES + 8; k++)
            push_item(KIND_EDGE, $urandom_range(0, 3), $urandom_range(0, 3), 0);
        push_item(KIND_WEIGHT, 3, 0, $urandom());
        push_item(KIND_COMPUTE, 0, 0, 0);
        push_item(KIND_EDGE, 1, 2, 0);
        push_item(KIND_COMPUTE, 0, 0, 0);

        // Random phases: small graphs mostly, a few at the extremes
        while (items_sent + item_queue.size() < 3200) begin
            pick_setting: begin
                n_pick = $urandom_range(0, 19);
                if (n_pick == 0) n_pick = 0;
                else if (n_pick == 1) n_pick = 256;
                else if (n_pick == 2) n_pick = $urandom_range(257, 511);
                else if (n_pick == 3) n_pick = 1;
                else n_pick = $urandom_range(2, 16);
            end
            write_node_count(n_pick);
            lim = n_pick == 0 ? 1 : (n_pick > NODES ? NODES : n_pick);
            calm = ($urandom_range(0, 3) == 0);
            random_graph(lim, $urandom_range(3, 30));
        end
        wait_idle();

        $display("Run covered %0d item transfers, %0d path sums checked, %0d node count writes.",
                 items_sent, sums_checked, cfg_writes);
        if (err_count == 0 && expected_sums.size() == 0)
            $display("ALL CHECKS PASSED");
        else begin
            $display("%0d mismatches, %0d results missing", err_count, expected_sums.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Hard stop in case the block hangs
    initial begin
        #200_000_000;
        $display("ERROR: timeout");
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
